// ===== rtl/median_filter_3x3_top_defines.svh =====
// Assertion macros shared by the 3x3 median filter RTL.
// Each macro samples on i_clk and is switched off while i_rst_n is low.
`ifndef MEDIAN_FILTER_3X3_TOP_DEFINES_SVH
`define MEDIAN_FILTER_3X3_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MF3_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MF3_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/mf3_pkg.sv =====
// Shared types, constants and helper functions of the 3x3 median filter.
// Used by every module of the block; depends on nothing else.
package mf3_pkg;

    localparam int MAX_WIDTH   = 2048;
    localparam int ADDR_W      = $clog2(MAX_WIDTH);
    localparam int EW          = ADDR_W + 1;
    localparam int WIDTH_REG_W = 12;
    localparam int HEIGHT_W    = 16;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_IDX_W   = 1;
    localparam int COL_W       = 11;
    localparam int ROW_W       = 16;
    localparam int BYTE_W      = 8;
    localparam int PIX_W       = 3 * BYTE_W;
    localparam int WIN_SIDE    = 3;
    localparam int WIN_TAPS    = 9;
    localparam int CENTRE_TAP  = 4;
    localparam int Q_DEPTH     = 4;
    localparam int Q_PTR_W     = $clog2(Q_DEPTH);
    localparam int Q_CNT_W     = Q_PTR_W + 1;

    localparam logic [WIDTH_REG_W-1:0] WIDTH_RESET  = WIDTH_REG_W'(640);
    localparam logic [HEIGHT_W-1:0]    HEIGHT_RESET = HEIGHT_W'(480);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } t_cfg_reg;

    typedef logic [BYTE_W-1:0] t_byte;
    typedef logic [PIX_W-1:0]  t_pixel;
    typedef t_byte [2:0]       t_tri;

    // Which results an item causes, in the order they are delivered.
    typedef struct packed {
        logic a_en;
        logic a_med;
        logic b_en;
        logic c_en;
    } t_cls;

    typedef struct packed {
        t_cls                       cls;
        logic [ADDR_W-1:0]          col;
        logic [ROW_W-1:0]           row;
        t_byte [WIN_TAPS-1:0]       taps;
        t_pixel                     centre;
        t_pixel                     lo;
        t_pixel                     px;
    } t_job;

    typedef struct packed {
        logic               empty;
        logic [Q_CNT_W-1:0] count;
    } t_q_status;

    // Sorts three bytes; element 0 is the smallest and element 2 the largest.
    function automatic t_tri sort3(input t_byte a, input t_byte b, input t_byte c);
        t_byte x0;
        t_byte x1;
        t_byte x2;
        t_byte tmp;
        x0 = a;
        x1 = b;
        x2 = c;
        if (x0 > x1) begin
            tmp = x0; x0 = x1; x1 = tmp;
        end
        if (x1 > x2) begin
            tmp = x1; x1 = x2; x2 = tmp;
        end
        if (x0 > x1) begin
            tmp = x0; x0 = x1; x1 = tmp;
        end
        return {x2, x1, x0};
    endfunction

    function automatic t_byte min2(input t_byte a, input t_byte b);
        return (a < b) ? a : b;
    endfunction

    function automatic t_byte max2(input t_byte a, input t_byte b);
        return (a > b) ? a : b;
    endfunction

    function automatic t_byte med3(input t_byte a, input t_byte b, input t_byte c);
        return max2(min2(a, b), min2(max2(a, b), c));
    endfunction

endpackage

// ===== rtl/mf3_front.sv =====
// Front end of the 3x3 median filter: configuration, raster counters,
// line stores and window. Classifies each pixel and hands jobs to the queue.
// Depends on mf3_pkg and the assertion macros header.
`include "median_filter_3x3_top_defines.svh"

module mf3_front
    import mf3_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  push,
    output logic                  full,
    input  t_byte                 i_channel_zero,
    input  t_byte                 i_channel_one,
    input  t_byte                 i_channel_two,
    input  t_q_status             i_q_status,
    output logic                  o_job_valid,
    output t_job                  o_job
);

    logic [WIDTH_REG_W-1:0] r_width;
    logic [HEIGHT_W-1:0]    r_height;
    logic [ADDR_W-1:0]      r_col;
    logic [ROW_W-1:0]       r_row;
    logic [EW-1:0]          r_fill;

    t_pixel r_mem_up [MAX_WIDTH];
    t_pixel r_mem_lo [MAX_WIDTH];
    t_pixel r_rd_up;
    t_pixel r_rd_lo;

    logic              r_s1_valid;
    logic [ADDR_W-1:0] r_s1_col;
    logic [ROW_W-1:0]  r_s1_row;
    t_cls              r_s1_cls;
    t_pixel            r_s1_px;
    logic              r_s1_hit;

    t_pixel [WIN_TAPS-1:0] r_win;
    t_pixel [WIN_TAPS-1:0] n_win;

    logic [EW-1:0]       w_eff;
    logic [HEIGHT_W-1:0] h_eff;
    logic                restart;
    logic [ADDR_W-1:0]   c;
    logic [ROW_W-1:0]    r;
    logic [EW-1:0]       c_plus;
    logic [ROW_W:0]      r_plus;
    logic [ADDR_W-1:0]   n_col;
    logic [ROW_W-1:0]    n_row;
    logic                hit;
    t_cls                cls;
    logic                accept;
    logic                s1_push;
    logic [Q_CNT_W:0]    used;
    t_pixel              up;
    t_pixel              lo;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RESET;
            r_height <= HEIGHT_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_idx))
                REG_IMAGE_WIDTH: begin
                    r_width <= i_cfg_data[WIDTH_REG_W-1:0];
                end
                REG_IMAGE_HEIGHT: begin
                    r_height <= i_cfg_data[HEIGHT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Effective frame size, position of the incoming pixel and its results.
    always_comb begin
        if (r_width < WIDTH_REG_W'(3)) begin
            w_eff = EW'(3);
        end else if ({1'b0, r_width} > (WIDTH_REG_W + 1)'(MAX_WIDTH)) begin
            w_eff = EW'(MAX_WIDTH);
        end else begin
            w_eff = EW'(r_width);
        end
        h_eff   = (r_height < HEIGHT_W'(3)) ? HEIGHT_W'(3) : r_height;
        restart = (EW'(r_col) >= w_eff) || (r_row >= h_eff);
        c       = restart ? '0 : r_col;
        r       = restart ? '0 : r_row;

        c_plus = EW'(c) + EW'(1);
        r_plus = (ROW_W + 1)'(r) + (ROW_W + 1)'(1);
        if (c_plus >= w_eff) begin
            n_col = '0;
            n_row = (r_plus >= (ROW_W + 1)'(h_eff)) ? '0 : r_plus[ROW_W-1:0];
        end else begin
            n_col = c_plus[ADDR_W-1:0];
            n_row = r;
        end

        hit       = EW'(c) < r_fill;
        cls.a_en  = (r != '0) && (c != '0);
        cls.a_med = (c >= ADDR_W'(2)) && (r >= ROW_W'(2));
        cls.b_en  = (r != '0) && (EW'(c) == w_eff - EW'(1));
        cls.c_en  = (r == h_eff - HEIGHT_W'(1));
    end

    // A job is only queued when the pixel causes at least one result.
    assign s1_push = r_s1_valid && (r_s1_cls.a_en || r_s1_cls.b_en || r_s1_cls.c_en);
    assign used    = (Q_CNT_W + 1)'(i_q_status.count) + (Q_CNT_W + 1)'(s1_push);
    assign full    = !i_rst_n || (used >= (Q_CNT_W + 1)'(Q_DEPTH));
    assign accept  = push && !full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept;
            if (accept) begin
                r_col <= n_col;
                r_row <= n_row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_col <= c;
            r_s1_row <= r;
            r_s1_cls <= cls;
            r_s1_px  <= {i_channel_two, i_channel_one, i_channel_zero};
            r_s1_hit <= hit;
        end
    end

    // Line stores: read when the pixel arrives, rotated in the following cycle.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd_up <= r_mem_up[c];
            r_rd_lo <= r_mem_lo[c];
        end
        if (r_s1_valid) begin
            r_mem_up[r_s1_col] <= lo;
            r_mem_lo[r_s1_col] <= r_s1_px;
        end
    end

    // Columns never written since reset read as zero; the written columns
    // always form a prefix, so a fill count is enough to tell them apart.
    always_comb begin
        up = r_s1_hit ? r_rd_up : '0;
        lo = r_s1_hit ? r_rd_lo : '0;
        for (int i = 0; i < WIN_SIDE; i++) begin
            n_win[i * WIN_SIDE]     = r_win[i * WIN_SIDE + 1];
            n_win[i * WIN_SIDE + 1] = r_win[i * WIN_SIDE + 2];
        end
        n_win[WIN_SIDE - 1]     = up;
        n_win[2 * WIN_SIDE - 1] = lo;
        n_win[WIN_TAPS - 1]     = r_s1_px;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win  <= '0;
            r_fill <= '0;
        end else if (r_s1_valid) begin
            r_win <= n_win;
            if (EW'(r_s1_col) == r_fill) begin
                r_fill <= r_fill + EW'(1);
            end
        end
    end

    always_comb begin
        o_job_valid = s1_push;
        o_job.cls   = r_s1_cls;
        o_job.col   = r_s1_col;
        o_job.row   = r_s1_row;
        for (int i = 0; i < WIN_TAPS; i++) begin
            o_job.taps[i] = n_win[i][BYTE_W-1:0];
        end
        o_job.centre = n_win[CENTRE_TAP];
        o_job.lo     = lo;
        o_job.px     = r_s1_px;
    end

    `MF3_ASSERT_NOW(a_fe_no_rw_clash, accept && r_s1_valid, c != r_s1_col, "line store read and write address the same column")
    `MF3_ASSERT_NOW(a_fe_fill_bound, r_s1_valid, r_fill <= EW'(MAX_WIDTH), "line store fill count beyond the store depth")

endmodule

// ===== rtl/mf3_queue.sv =====
// Short job queue between the front and the back of the median filter.
// Depends on mf3_pkg and the assertion macros header.
`include "median_filter_3x3_top_defines.svh"

module mf3_queue
    import mf3_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_wr,
    input  t_job      i_wdata,
    input  logic      i_rd,
    output t_job      o_rdata,
    output t_q_status o_status
);

    t_job               r_q [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wp;
    logic [Q_PTR_W-1:0] r_rp;
    logic [Q_CNT_W-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_wr) begin
                r_wp <= r_wp + Q_PTR_W'(1);
            end
            if (i_rd) begin
                r_rp <= r_rp + Q_PTR_W'(1);
            end
            r_count <= r_count + Q_CNT_W'(i_wr) - Q_CNT_W'(i_rd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_q[r_wp] <= i_wdata;
        end
    end

    assign o_rdata        = r_q[r_rp];
    assign o_status.empty = (r_count == '0);
    assign o_status.count = r_count;

    `MF3_ASSERT_NOW(a_q_no_overflow, i_wr && !i_rd, r_count < Q_CNT_W'(Q_DEPTH), "job queue written while full")
    `MF3_ASSERT_NOW(a_q_no_underflow, i_rd, r_count != '0, "job queue read while empty")

endmodule

// ===== rtl/mf3_back.sv =====
// Back end of the median filter: two-stage median network, then expansion
// of each job into its results and the output register.
// Depends on mf3_pkg and the assertion macros header.
`include "median_filter_3x3_top_defines.svh"

module mf3_back
    import mf3_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_q_status         i_q_status,
    input  t_job              i_job,
    output logic              o_q_rd,
    input  logic              pop,
    output logic              empty,
    output t_byte             o_out_zero,
    output t_byte             o_out_one,
    output t_byte             o_out_two,
    output logic [COL_W-1:0]  o_column,
    output logic [ROW_W-1:0]  o_row,
    output logic              o_last_of_run
);

    localparam int PEND_A = 0;
    localparam int PEND_B = 1;
    localparam int PEND_C = 2;

    logic  r_p1_valid;
    t_job  r_p1_job;
    logic  r_p2_valid;
    t_job  r_p2_job;
    t_tri  r_p2_cand;

    logic              r_ex_valid;
    logic [2:0]        r_ex_pend;
    logic              r_ex_med_en;
    t_byte             r_ex_med;
    logic [ADDR_W-1:0] r_ex_col;
    logic [ROW_W-1:0]  r_ex_row;
    t_pixel            r_ex_centre;
    t_pixel            r_ex_lo;
    t_pixel            r_ex_px;

    logic              r_o_valid;
    t_pixel            r_o_pix;
    logic [ADDR_W-1:0] r_o_col;
    logic [ROW_W-1:0]  r_o_row;
    logic              r_o_last;

    t_job              p1_in;
    t_tri              p2_cand;
    logic [2:0]        n_pend;
    t_pixel            e_pix;
    logic [ADDR_W-1:0] e_col;
    logic [ROW_W-1:0]  e_row;
    logic              e_last;
    logic              out_free;
    logic              emit;
    logic              ex_take;
    logic              p2_move;
    logic              p2_take;
    logic              p1_take;

    // First stage of the network: sort each row of the window.
    always_comb begin
        t_tri srt;
        p1_in = i_job;
        for (int i = 0; i < WIN_SIDE; i++) begin
            srt = sort3(i_job.taps[i * WIN_SIDE], i_job.taps[i * WIN_SIDE + 1],
                        i_job.taps[i * WIN_SIDE + 2]);
            for (int k = 0; k < WIN_SIDE; k++) begin
                p1_in.taps[i * WIN_SIDE + k] = srt[k];
            end
        end
    end

    // Second stage: the median lies between the largest row minimum, the
    // median of row medians and the smallest row maximum.
    always_comb begin
        p2_cand[0] = max2(max2(r_p1_job.taps[0], r_p1_job.taps[3]), r_p1_job.taps[6]);
        p2_cand[1] = med3(r_p1_job.taps[1], r_p1_job.taps[4], r_p1_job.taps[7]);
        p2_cand[2] = min2(min2(r_p1_job.taps[2], r_p1_job.taps[5]), r_p1_job.taps[8]);
    end

    // Pick the next result of the job held in the expander.
    always_comb begin
        n_pend = r_ex_pend;
        e_pix  = r_ex_px;
        e_col  = r_ex_col;
        e_row  = r_ex_row;
        if (r_ex_pend[PEND_A]) begin
            n_pend[PEND_A] = 1'b0;
            e_pix = r_ex_med_en ? {3{r_ex_med}} : r_ex_centre;
            e_col = r_ex_col - ADDR_W'(1);
            e_row = r_ex_row - ROW_W'(1);
        end else if (r_ex_pend[PEND_B]) begin
            n_pend[PEND_B] = 1'b0;
            e_pix = r_ex_lo;
            e_row = r_ex_row - ROW_W'(1);
        end else begin
            n_pend[PEND_C] = 1'b0;
        end
        e_last = (n_pend == '0);
    end

    always_comb begin
        out_free = !r_o_valid || pop;
        emit     = r_ex_valid && out_free;
        ex_take  = !r_ex_valid || (emit && e_last);
        p2_move  = r_p2_valid && ex_take;
        p2_take  = !r_p2_valid || ex_take;
        p1_take  = !r_p1_valid || p2_take;
        o_q_rd   = !i_q_status.empty && p1_take;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid <= 1'b0;
            r_p2_valid <= 1'b0;
            r_ex_valid <= 1'b0;
            r_ex_pend  <= '0;
            r_o_valid  <= 1'b0;
        end else begin
            if (p1_take) begin
                r_p1_valid <= o_q_rd;
            end
            if (p2_take) begin
                r_p2_valid <= r_p1_valid;
            end
            if (ex_take) begin
                r_ex_valid <= r_p2_valid;
            end
            if (p2_move) begin
                r_ex_pend <= {r_p2_job.cls.c_en, r_p2_job.cls.b_en, r_p2_job.cls.a_en};
            end else if (emit) begin
                r_ex_pend <= n_pend;
            end
            if (emit) begin
                r_o_valid <= 1'b1;
            end else if (pop) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_rd && p1_take) begin
            r_p1_job <= p1_in;
        end
        if (r_p1_valid && p2_take) begin
            r_p2_job  <= r_p1_job;
            r_p2_cand <= p2_cand;
        end
        if (p2_move) begin
            r_ex_med_en <= r_p2_job.cls.a_med;
            r_ex_med    <= med3(r_p2_cand[0], r_p2_cand[1], r_p2_cand[2]);
            r_ex_col    <= r_p2_job.col;
            r_ex_row    <= r_p2_job.row;
            r_ex_centre <= r_p2_job.centre;
            r_ex_lo     <= r_p2_job.lo;
            r_ex_px     <= r_p2_job.px;
        end
        if (emit) begin
            r_o_pix  <= e_pix;
            r_o_col  <= e_col;
            r_o_row  <= e_row;
            r_o_last <= e_last;
        end
    end

    assign empty         = !r_o_valid || !i_rst_n;
    assign o_out_zero    = r_o_pix[BYTE_W-1:0];
    assign o_out_one     = r_o_pix[2*BYTE_W-1:BYTE_W];
    assign o_out_two     = r_o_pix[3*BYTE_W-1:2*BYTE_W];
    assign o_column      = COL_W'(r_o_col);
    assign o_row         = r_o_row;
    assign o_last_of_run = r_o_last;

    `MF3_ASSERT_NOW(a_be_pend, r_ex_valid, r_ex_pend != '0, "expander holds a job with no result left")
    `MF3_ASSERT_NEXT(a_be_p1_hold, r_p1_valid && !p2_take, r_p1_valid && $stable(r_p1_job), "stalled sort stage lost its job")

endmodule

// ===== rtl/median_filter_3x3_top.sv =====
// Path: front stage, job queue, sort and median stages, expander, then the output register.
// Throughput: one pixel per cycle while each pixel causes at most one result and pop keeps the
// output free; the output register moves one result per cycle, so pixels of the right-hand
// column or the last row (up to three results) can hold the input back.
// Reset: synchronous, active low; counters clear, sizes return to 640 x 480, and the line
// stores read as zero through a fill count, so no clearing pass is needed.
// Top level of the 3x3 median filter; depends on mf3_pkg, mf3_front, mf3_queue and mf3_back.
module median_filter_3x3_top
    import mf3_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  push,
    output logic                  full,
    input  logic [BYTE_W-1:0]     i_channel_zero,
    input  logic [BYTE_W-1:0]     i_channel_one,
    input  logic [BYTE_W-1:0]     i_channel_two,
    output logic                  empty,
    input  logic                  pop,
    output logic [BYTE_W-1:0]     o_out_zero,
    output logic [BYTE_W-1:0]     o_out_one,
    output logic [BYTE_W-1:0]     o_out_two,
    output logic [COL_W-1:0]      o_column,
    output logic [ROW_W-1:0]      o_row,
    output logic                  o_last_of_run
);

    logic      job_valid;
    t_job      job;
    t_job      q_job;
    t_q_status q_status;
    logic      q_rd;

    mf3_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .push           (push),
        .full           (full),
        .i_channel_zero (i_channel_zero),
        .i_channel_one  (i_channel_one),
        .i_channel_two  (i_channel_two),
        .i_q_status     (q_status),
        .o_job_valid    (job_valid),
        .o_job          (job)
    );

    mf3_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (job_valid),
        .i_wdata  (job),
        .i_rd     (q_rd),
        .o_rdata  (q_job),
        .o_status (q_status)
    );

    mf3_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_status    (q_status),
        .i_job         (q_job),
        .o_q_rd        (q_rd),
        .pop           (pop),
        .empty         (empty),
        .o_out_zero    (o_out_zero),
        .o_out_one     (o_out_one),
        .o_out_two     (o_out_two),
        .o_column      (o_column),
        .o_row         (o_row),
        .o_last_of_run (o_last_of_run)
    );

endmodule
